// File: sv/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants for the 3x3 rgb median filter
// field widths, register indexes, size limits and reset values
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MAX_HEIGHT        = 4095;

   localparam int CHAN_WIDTH      = 8;
   localparam int ROW_WIDTH       = 12;
   localparam int COL_WIDTH       = 10;
   localparam int CFG_WIDTH_BITS  = 11;
   localparam int CFG_HEIGHT_BITS = 12;
   localparam int SIZE_WIDTH      = 13;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CFG_WIDTH_BITS-1:0]  IMAGE_WIDTH_RESET  = 11'd256;
   localparam logic [CFG_HEIGHT_BITS-1:0] IMAGE_HEIGHT_RESET = 12'd256;

   // register indexes on the csr channel
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IMAGE_HEIGHT = 4'd1;

   typedef logic [CHAN_WIDTH-1:0] chan_type;
   typedef logic [3*CHAN_WIDTH-1:0] rgb_type;

   // which results a pixel causes
   typedef struct packed {
      logic emit_a;    // pixel (r-1, c-1)
      logic filt;      // that pixel is interior
      logic emit_b;    // pixel (r-1, w-1) at the right edge
      logic emit_c;    // the input itself on the bottom row
   } emit_type;

endpackage

// File: sv/mf3_channels_if.sv
// ----------------------------------------------------------------------------
// mf3 channel interfaces
// valid/ready channels for pixels in, results out and register writes
// ----------------------------------------------------------------------------
interface mf3_req_if;
   logic                valid;
   logic                ready;
   mf3_pkg::chan_type   in_red;
   mf3_pkg::chan_type   in_green;
   mf3_pkg::chan_type   in_blue;

   modport source (output valid, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface mf3_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mf3_pkg::ROW_WIDTH-1:0]     out_row;
   logic [mf3_pkg::COL_WIDTH-1:0]     out_col;
   mf3_pkg::chan_type                 out_red;
   mf3_pkg::chan_type                 out_green;
   mf3_pkg::chan_type                 out_blue;
   logic                              is_filtered;
   logic                              last_of_run;

   modport source (output valid, out_row, out_col, out_red, out_green, out_blue,
                   is_filtered, last_of_run, input ready);
   modport sink   (input valid, out_row, out_col, out_red, out_green, out_blue,
                   is_filtered, last_of_run, output ready);
endinterface

interface mf3_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [mf3_pkg::CSR_INDEX_WIDTH-1:0]   reg_index;
   logic [mf3_pkg::CSR_DATA_WIDTH-1:0]    wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// File: sv/median_filter_3x3_rgb.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb: streaming 3x3 median filter for 24-bit rgb frames
// two line buffers in one memory, a 3x3 window and a pipelined median network
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  req_bus   in   valid/ready    in_red, in_green, in_blue (raster order)
//  rsp_bus   out  valid/ready    out_row, out_col, rgb, is_filtered, last_of_run
//  csr_bus   in   valid/ready    reg_index, wr_data (0 width, 1 height)
//
//  one pixel is taken per cycle unless the stages behind are full; a pixel
//  that causes k results holds the result stage until all k are sent, one
//  result per cycle while rsp_bus is ready (k is 0..3, more than one only
//  at the right edge and on the bottom row); a pixel's first result passes
//  through the registered steps memory read, window and row sort, column
//  merge, final median; the line memory takes one read and one write per cycle
//  reset clears counters and stage valids; the line memory is not cleared
//  a stalled result stage fills the stages behind it before req_bus stalls
// ----------------------------------------------------------------------------
module median_filter_3x3_rgb #(
   parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   mf3_req_if.sink          req_bus,
   mf3_rsp_if.source        rsp_bus,
   mf3_csr_if.sink          csr_bus
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int SW = mf3_pkg::SIZE_WIDTH;
   localparam int RW = mf3_pkg::ROW_WIDTH;
   localparam int OCW = mf3_pkg::COL_WIDTH;

   // ---------------- helper functions ----------------

   // returns {max, mid, min}
   function automatic logic [23:0] sort3(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c < lo) begin
         sort3 = {hi, lo, c};
      end else if (c > hi) begin
         sort3 = {c, hi, lo};
      end else begin
         sort3 = {hi, c, lo};
      end
   endfunction

   function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] lo;
      logic [7:0] hi;
      logic [7:0] t;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      t = (hi < c) ? hi : c;
      med3 = (lo > t) ? lo : t;
   endfunction

   function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] t;
      t = (a > b) ? a : b;
      max3 = (t > c) ? t : c;
   endfunction

   function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] t;
      t = (a < b) ? a : b;
      min3 = (t < c) ? t : c;
   endfunction

   // ---------------- configuration ----------------

   logic [mf3_pkg::CFG_WIDTH_BITS-1:0]  width_ff;
   logic [mf3_pkg::CFG_HEIGHT_BITS-1:0] height_ff;
   logic csr_xfer;
   logic csr_known;

   assign csr_bus.ready = 1'b1;
   assign csr_xfer = csr_bus.valid && csr_bus.ready;

   always_comb begin
      case (csr_bus.reg_index)
         mf3_pkg::REG_IMAGE_WIDTH:  csr_known = 1'b1;
         mf3_pkg::REG_IMAGE_HEIGHT: csr_known = 1'b1;
         default:                   csr_known = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mf3_pkg::IMAGE_WIDTH_RESET;
         height_ff <= mf3_pkg::IMAGE_HEIGHT_RESET;
      end else if (csr_xfer) begin
         case (csr_bus.reg_index)
            mf3_pkg::REG_IMAGE_WIDTH:
               width_ff <= csr_bus.wr_data[mf3_pkg::CFG_WIDTH_BITS-1:0];
            mf3_pkg::REG_IMAGE_HEIGHT:
               height_ff <= csr_bus.wr_data[mf3_pkg::CFG_HEIGHT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // clamped frame size
   logic [SW-1:0] eff_w;
   logic [RW-1:0] eff_h;

   always_comb begin
      eff_w = SW'(width_ff);
      if (eff_w < SW'(3)) eff_w = SW'(3);
      if (eff_w > SW'(MAX_WIDTH)) eff_w = SW'(MAX_WIDTH);
      eff_h = height_ff;
      if (eff_h < RW'(3)) eff_h = RW'(3);
      if (eff_h > RW'(mf3_pkg::MAX_HEIGHT)) eff_h = RW'(mf3_pkg::MAX_HEIGHT);
   end

   // ---------------- pipeline control ----------------

   logic       v1_ff, v2_ff, v3_ff;
   logic [2:0] pend_ff;
   logic       exp_take, s3_free, s2_free, s1_free;
   logic       s1_move, req_xfer, rsp_xfer;

   assign rsp_xfer = rsp_bus.valid && rsp_bus.ready;
   // result stage takes a new pixel when empty or sending its last result
   assign exp_take = (pend_ff == 3'b000) || ($onehot(pend_ff) && rsp_bus.ready);
   assign s3_free  = !v3_ff || exp_take;
   assign s2_free  = !v2_ff || s3_free;
   assign s1_free  = !v1_ff || s2_free;
   assign s1_move  = v1_ff && s2_free;
   assign req_bus.ready = s1_free;
   assign req_xfer = req_bus.valid && req_bus.ready;

   // ---------------- raster counters ----------------

   logic [RW-1:0] row_ff, row_in, r_cur;
   logic [CW-1:0] col_ff, col_in, c_cur;
   mf3_pkg::emit_type emit_cur;
   logic at_right;
   logic at_bottom;

   always_comb begin
      r_cur = row_ff;
      c_cur = col_ff;
      // guard against counters outside the frame
      if ((SW'(col_ff) >= eff_w) || (row_ff >= eff_h)) begin
         r_cur = '0;
         c_cur = '0;
      end
      at_right  = (SW'(c_cur) == (eff_w - SW'(1)));
      at_bottom = (r_cur == (eff_h - RW'(1)));
      emit_cur.emit_a = (r_cur != '0) && (c_cur != '0);
      emit_cur.filt   = (r_cur >= RW'(2)) && (c_cur >= CW'(2));
      emit_cur.emit_b = (r_cur != '0) && at_right;
      emit_cur.emit_c = at_bottom;
      if (at_right) begin
         col_in = '0;
         row_in = at_bottom ? '0 : (r_cur + RW'(1));
      end else begin
         col_in = c_cur + CW'(1);
         row_in = r_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (csr_xfer && csr_known) begin
         // a write to a known register restarts the frame
         row_ff <= '0;
         col_ff <= '0;
      end else if (req_xfer) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------- line memory: {row r-2, row r-1} per column ----------------

   logic [47:0] line_mem [MAX_WIDTH];
   logic [47:0] mem_rd_ff;
   mf3_pkg::rgb_type in_pix;

   assign in_pix = {req_bus.in_red, req_bus.in_green, req_bus.in_blue};

   // stage 1 registers
   mf3_pkg::rgb_type  s1_pix_ff;
   logic [RW-1:0]     s1_row_ff;
   logic [CW-1:0]     s1_col_ff;
   mf3_pkg::emit_type s1_emit_ff;

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mem_rd_ff <= line_mem[c_cur];
      end
      // read-modify-write: row r-1 moves down to r-2, the new pixel becomes r-1
      if (s1_move) begin
         line_mem[s1_col_ff] <= {mem_rd_ff[23:0], s1_pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (s1_free) begin
         v1_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pix_ff  <= in_pix;
         s1_row_ff  <= r_cur;
         s1_col_ff  <= c_cur;
         s1_emit_ff <= emit_cur;
      end
   end

   // ---------------- stage 1: window shift and row sort ----------------

   mf3_pkg::rgb_type win_ff [9];
   mf3_pkg::rgb_type win_in [9];
   logic [23:0]      sort_in [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i*3+0] = win_ff[i*3+1];
         win_in[i*3+1] = win_ff[i*3+2];
      end
      win_in[2] = mem_rd_ff[47:24];
      win_in[5] = mem_rd_ff[23:0];
      win_in[8] = s1_pix_ff;
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < 3; i++) begin
            sort_in[ch][i] = sort3(win_in[i*3+0][8*(2-ch) +: 8],
                                   win_in[i*3+1][8*(2-ch) +: 8],
                                   win_in[i*3+2][8*(2-ch) +: 8]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   // stage 2 registers
   logic [23:0]       s2_sort_ff [3][3];
   mf3_pkg::rgb_type  s2_center_ff, s2_right_ff, s2_pix_ff;
   logic [RW-1:0]     s2_row_ff;
   logic [CW-1:0]     s2_col_ff;
   mf3_pkg::emit_type s2_emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (s2_free) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_sort_ff   <= sort_in;
         s2_center_ff <= win_in[4];
         s2_right_ff  <= win_in[5];
         s2_pix_ff    <= s1_pix_ff;
         s2_row_ff    <= s1_row_ff;
         s2_col_ff    <= s1_col_ff;
         s2_emit_ff   <= s1_emit_ff;
      end
   end

   // ---------------- stage 2: max of mins, median of mids, min of maxes ----------------

   logic [23:0] lmh_in [3];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         lmh_in[ch] = {min3(s2_sort_ff[ch][0][23:16], s2_sort_ff[ch][1][23:16],
                            s2_sort_ff[ch][2][23:16]),
                       med3(s2_sort_ff[ch][0][15:8], s2_sort_ff[ch][1][15:8],
                            s2_sort_ff[ch][2][15:8]),
                       max3(s2_sort_ff[ch][0][7:0], s2_sort_ff[ch][1][7:0],
                            s2_sort_ff[ch][2][7:0])};
      end
   end

   logic [23:0]       s3_lmh_ff [3];
   mf3_pkg::rgb_type  s3_center_ff, s3_right_ff, s3_pix_ff;
   logic [RW-1:0]     s3_row_ff;
   logic [CW-1:0]     s3_col_ff;
   mf3_pkg::emit_type s3_emit_ff;
   logic              s2_move;

   assign s2_move = v2_ff && s3_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (s3_free) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         s3_lmh_ff    <= lmh_in;
         s3_center_ff <= s2_center_ff;
         s3_right_ff  <= s2_right_ff;
         s3_pix_ff    <= s2_pix_ff;
         s3_row_ff    <= s2_row_ff;
         s3_col_ff    <= s2_col_ff;
         s3_emit_ff   <= s2_emit_ff;
      end
   end

   // ---------------- stage 3: final median, load result stage ----------------

   mf3_pkg::rgb_type med_rgb;
   logic             s3_move;

   assign s3_move = v3_ff && exp_take;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         med_rgb[8*(2-ch) +: 8] = med3(s3_lmh_ff[ch][23:16], s3_lmh_ff[ch][15:8],
                                       s3_lmh_ff[ch][7:0]);
      end
   end

   mf3_pkg::rgb_type e_rgb_a_ff, e_rgb_b_ff, e_rgb_c_ff;
   logic             e_filt_ff;
   logic [RW-1:0]    e_row_ff;
   logic [CW-1:0]    e_col_ff;
   logic [2:0]       pend_in;
   logic [2:0]       pend_sel;

   // lowest pending result goes out first: a, then b, then c
   assign pend_sel = pend_ff & (~pend_ff + 3'd1);

   always_comb begin
      pend_in = pend_ff;
      if (s3_move) begin
         pend_in = {s3_emit_ff.emit_c, s3_emit_ff.emit_b, s3_emit_ff.emit_a};
      end else if (rsp_xfer) begin
         pend_in = pend_ff & ~pend_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 3'b000;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_move) begin
         e_rgb_a_ff <= s3_emit_ff.filt ? med_rgb : s3_center_ff;
         e_rgb_b_ff <= s3_right_ff;
         e_rgb_c_ff <= s3_pix_ff;
         e_filt_ff  <= s3_emit_ff.filt;
         e_row_ff   <= s3_row_ff;
         e_col_ff   <= s3_col_ff;
      end
   end

   // ---------------- result channel ----------------

   logic [CW-1:0]     out_c;
   logic [CW+OCW-1:0] out_c_ext;
   mf3_pkg::rgb_type  out_rgb;

   always_comb begin
      if (pend_sel[0]) begin
         rsp_bus.out_row     = e_row_ff - RW'(1);
         out_c               = e_col_ff - CW'(1);
         out_rgb             = e_rgb_a_ff;
         rsp_bus.is_filtered = e_filt_ff;
      end else if (pend_sel[1]) begin
         rsp_bus.out_row     = e_row_ff - RW'(1);
         out_c               = e_col_ff;
         out_rgb             = e_rgb_b_ff;
         rsp_bus.is_filtered = 1'b0;
      end else begin
         rsp_bus.out_row     = e_row_ff;
         out_c               = e_col_ff;
         out_rgb             = e_rgb_c_ff;
         rsp_bus.is_filtered = 1'b0;
      end
      out_c_ext = {{OCW{1'b0}}, out_c};
   end

   assign rsp_bus.valid       = (pend_ff != 3'b000);
   assign rsp_bus.out_col     = out_c_ext[OCW-1:0];
   assign rsp_bus.out_red     = out_rgb[23:16];
   assign rsp_bus.out_green   = out_rgb[15:8];
   assign rsp_bus.out_blue    = out_rgb[7:0];
   assign rsp_bus.last_of_run = $onehot(pend_ff);

   // ---------------- assertions ----------------

   // read and write-back never hit the same column in one cycle
   a_mem_no_collide: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && s1_move) |-> (c_cur != s1_col_ff))
      else $error("line memory read and write on the same column");

   // a taken pixel always lands in stage 1
   a_req_to_s1: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> v1_ff)
      else $error("accepted pixel lost before stage 1");

   // filtered results are never on the top row or left column
   a_filt_interior: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.is_filtered) |->
         ((rsp_bus.out_row != '0) && (rsp_bus.out_col != '0)))
      else $error("filtered result on the border");

   // a stalled result stage keeps its pending results
   a_pend_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> (pend_ff == $past(pend_ff)))
      else $error("pending results changed while stalled");

endmodule

// File: test/tb_median_filter_3x3_rgb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_median_filter_3x3_rgb: self-checking bench for the 3x3 rgb median filter
// streams raster-order frames of many sizes through the block, predicts every
// result from a behavioral copy of the window and line buffers, and compares
// each result transfer field by field under random stalls on both channels
// ----------------------------------------------------------------------------
module tb_median_filter_3x3_rgb;

   localparam int STALL_LIMIT   = 2000;   // cycles without any transfer
   localparam int DRAIN_CYCLES  = 8;      // pipeline is 4 deep
   localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
   localparam int RESET_PIXELS  = 8;      // first row only at reset sizes
   localparam int WIDE_PIXELS   = 20;
   localparam int TALL_PIXELS   = 40;
   localparam int RANDOM_PIXELS = 140;
   localparam int CALM_FROM     = 100;    // no idling past this point
   localparam int CALM_PIXELS   = 20;

   typedef struct {
      logic [mf3_pkg::ROW_WIDTH-1:0] row;
      logic [mf3_pkg::COL_WIDTH-1:0] col;
      mf3_pkg::rgb_type              rgb;
      logic                          filtered;
      logic                          last_of_run;
   } filter_result_type;

   logic clock = 1'b0;
   logic reset;

   mf3_req_if req_bus ();
   mf3_rsp_if rsp_bus ();
   mf3_csr_if csr_bus ();

   median_filter_3x3_rgb dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor state: registers, raster position, line buffers, window
   // ---------------------------------------------------------------------
   logic [mf3_pkg::CFG_WIDTH_BITS-1:0]  cfg_width;
   logic [mf3_pkg::CFG_HEIGHT_BITS-1:0] cfg_height;
   int                                  row_pos;
   int                                  col_pos;
   mf3_pkg::rgb_type line_above  [mf3_pkg::MAX_WIDTH_DEFAULT];
   mf3_pkg::rgb_type line_above2 [mf3_pkg::MAX_WIDTH_DEFAULT];
   mf3_pkg::rgb_type window_px   [9];   // [row*3 + col], col 2 newest

   filter_result_type pending_results [$];
   mf3_pkg::rgb_type  pixels_to_send  [$];

   int   mismatch_count = 0;
   logic idle_enable    = 1'b1;
   logic hold_armed     = 1'b0;

   // sizes as the block uses them, clamped to the legal range
   function automatic int effective_width();
      if (cfg_width < 3) return 3;
      if (cfg_width > mf3_pkg::MAX_WIDTH_DEFAULT) return mf3_pkg::MAX_WIDTH_DEFAULT;
      return int'(cfg_width);
   endfunction

   function automatic int effective_height();
      if (cfg_height < 3) return 3;
      if (cfg_height > mf3_pkg::MAX_HEIGHT) return mf3_pkg::MAX_HEIGHT;
      return int'(cfg_height);
   endfunction

   // fifth smallest of the nine window samples of one channel
   function automatic mf3_pkg::chan_type window_median(int shift);
      mf3_pkg::chan_type v [9];
      mf3_pkg::chan_type x;
      int                j;
      for (int i = 0; i < 9; i++) begin
         x = mf3_pkg::chan_type'(window_px[i] >> shift);
         j = i;
         while (j > 0 && v[j-1] > x) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = x;
      end
      return v[4];
   endfunction

   function automatic filter_result_type make_result(int row, int col,
                                                     mf3_pkg::rgb_type rgb,
                                                     logic filtered);
      filter_result_type res;
      res.row         = row[mf3_pkg::ROW_WIDTH-1:0];
      res.col         = col[mf3_pkg::COL_WIDTH-1:0];
      res.rgb         = rgb;
      res.filtered    = filtered;
      res.last_of_run = 1'b0;
      return res;
   endfunction

   // one accepted pixel: move the window, update the line buffers and queue
   // the results it causes, in the order the block sends them
   function automatic void advance_filter(mf3_pkg::rgb_type pix);
      int                w;
      int                h;
      int                r;
      int                c;
      int                n;
      filter_result_type res [3];
      w = effective_width();
      h = effective_height();
      r = row_pos;
      c = col_pos;
      n = 0;
      if (c >= w || r >= h) begin
         r = 0;
         c = 0;
      end
      for (int i = 0; i < 3; i++) begin
         window_px[i*3]   = window_px[i*3+1];
         window_px[i*3+1] = window_px[i*3+2];
      end
      window_px[2]   = line_above2[c];
      window_px[5]   = line_above[c];
      window_px[8]   = pix;
      line_above2[c] = line_above[c];
      line_above[c]  = pix;

      // center of the window, filtered only away from the top and left border
      if (r >= 1 && c >= 1) begin
         if (r >= 2 && c >= 2)
            res[n] = make_result(r - 1, c - 1,
                                 {window_median(16), window_median(8), window_median(0)},
                                 1'b1);
         else
            res[n] = make_result(r - 1, c - 1, window_px[4], 1'b0);
         n++;
      end
      // right border pixel of the row above
      if (r >= 1 && c == w - 1) begin
         res[n] = make_result(r - 1, c, window_px[5], 1'b0);
         n++;
      end
      // bottom row goes straight through
      if (r == h - 1) begin
         res[n] = make_result(r, c, pix, 1'b0);
         n++;
      end
      for (int i = 0; i < n; i++) begin
         res[i].last_of_run = (i == n - 1);
         pending_results.push_back(res[i]);
      end

      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // ---------------------------------------------------------------------
   // pixel driver: one transfer per free slot, random idle bursts
   // ---------------------------------------------------------------------
   int req_gap = 0;

   always @(posedge clock) begin
      mf3_pkg::rgb_type next_pix;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            advance_filter({req_bus.in_red, req_bus.in_green, req_bus.in_blue});
         // slot is free when nothing is offered or the offer was just taken
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pixels_to_send.size() != 0) begin
               next_pix = pixels_to_send.pop_front();
               {req_bus.in_red, req_bus.in_green, req_bus.in_blue} <= next_pix;
               req_bus.valid <= 1'b1;
               if (idle_enable && $urandom_range(0, 11) == 0)
                  req_gap = $urandom_range(1, 10);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // result monitor: checks each transfer, drives ready with stall bursts
   // and one long hold-off so the pipeline backs up into req_bus
   // ---------------------------------------------------------------------
   int   rsp_gap   = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;

   always @(posedge clock) begin
      filter_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               $error("result at row %0d col %0d with nothing pending",
                      rsp_bus.out_row, rsp_bus.out_col);
            end else begin
               want = pending_results.pop_front();
               check_field("out_row", 32'(want.row), 32'(rsp_bus.out_row));
               check_field("out_col", 32'(want.col), 32'(rsp_bus.out_col));
               check_field("out_red", 32'(want.rgb[23:16]), 32'(rsp_bus.out_red));
               check_field("out_green", 32'(want.rgb[15:8]), 32'(rsp_bus.out_green));
               check_field("out_blue", 32'(want.rgb[7:0]), 32'(rsp_bus.out_blue));
               check_field("is_filtered", 32'(want.filtered), 32'(rsp_bus.is_filtered));
               check_field("last_of_run", 32'(want.last_of_run),
                           32'(rsp_bus.last_of_run));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (idle_enable && $urandom_range(0, 15) == 0)
               rsp_gap = $urandom_range(1, 10);
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: no transfer on any channel for too long ends the run
   // ---------------------------------------------------------------------
   int stall_count = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("tb_median_filter_3x3_rgb NOT OK");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // mostly random, with channel extremes often enough to force ties
   function automatic mf3_pkg::rgb_type random_pixel();
      mf3_pkg::chan_type ch [3];
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 5))
            0:       ch[i] = 8'h00;
            1:       ch[i] = 8'hFF;
            default: ch[i] = mf3_pkg::chan_type'($urandom);
         endcase
      end
      return {ch[0], ch[1], ch[2]};
   endfunction

   function automatic void queue_random_pixels(int count);
      for (int i = 0; i < count; i++)
         pixels_to_send.push_back(random_pixel());
   endfunction

   // idle means every pixel taken, every result seen, pipeline flushed
   task automatic wait_for_drain();
      do @(negedge clock);
      while (pixels_to_send.size() != 0 || req_bus.valid || pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [mf3_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 logic [mf3_pkg::CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= index;
      csr_bus.wr_data   <= data;
      do @(posedge clock);
      while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      // any known register restarts the frame, buffers keep their contents
      if (index == mf3_pkg::REG_IMAGE_WIDTH) begin
         cfg_width = data[mf3_pkg::CFG_WIDTH_BITS-1:0];
         row_pos   = 0;
         col_pos   = 0;
      end else if (index == mf3_pkg::REG_IMAGE_HEIGHT) begin
         cfg_height = data[mf3_pkg::CFG_HEIGHT_BITS-1:0];
         row_pos    = 0;
         col_pos    = 0;
      end
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   mf3_pkg::rgb_type corner_pixels [9] = '{
      24'h000000, 24'hFFFFFF, 24'h55AA55, 24'hAA55AA, 24'h0180FF,
      24'hFE7F00, 24'h123456, 24'h00FF00, 24'hFF00FF
   };

   initial begin
      int                                 random_pixels;
      int                                 w_raw;
      int                                 h_raw;
      int                                 frame_len;
      int                                 burst;
      logic [mf3_pkg::CSR_DATA_WIDTH-1:0] w_data;
      logic [mf3_pkg::CSR_DATA_WIDTH-1:0] h_data;

      random_pixels = 0;
      cfg_width     = mf3_pkg::IMAGE_WIDTH_RESET;
      cfg_height    = mf3_pkg::IMAGE_HEIGHT_RESET;
      row_pos       = 0;
      col_pos       = 0;
      foreach (window_px[i]) window_px[i] = '0;

      req_bus.valid     = 1'b0;
      req_bus.in_red    = '0;
      req_bus.in_green  = '0;
      req_bus.in_blue   = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.reg_index = '0;
      csr_bus.wr_data   = '0;

      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset sizes: a few pixels of the first row, which cause no results
      queue_random_pixels(RESET_PIXELS);
      wait_for_drain();

      // smallest frame with extreme colors, then wrap into the next frame
      write_register(mf3_pkg::REG_IMAGE_WIDTH, 16'd3);
      write_register(mf3_pkg::REG_IMAGE_HEIGHT, 16'd3);
      foreach (corner_pixels[i]) pixels_to_send.push_back(corner_pixels[i]);
      queue_random_pixels(4);
      wait_for_drain();

      // unknown indexes must not disturb the frame in progress
      for (int i = int'(mf3_pkg::REG_IMAGE_HEIGHT) + 1; i < 2 ** mf3_pkg::CSR_INDEX_WIDTH;
           i++)
         write_register(i[mf3_pkg::CSR_INDEX_WIDTH-1:0], 16'($urandom));
      queue_random_pixels(5);
      wait_for_drain();

      // widest frame: width clamps down from all ones, height up from zero;
      // a short stretch of its first row
      write_register(mf3_pkg::REG_IMAGE_WIDTH, 16'hFFFF);
      write_register(mf3_pkg::REG_IMAGE_HEIGHT, 16'hF000);
      queue_random_pixels(WIDE_PIXELS);
      wait_for_drain();

      // tallest frame, with the long result hold-off while pixels keep coming
      write_register(mf3_pkg::REG_IMAGE_WIDTH, 16'hF803);
      write_register(mf3_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
      hold_armed = 1'b1;
      queue_random_pixels(TALL_PIXELS);
      wait_for_drain();

      // back to small sizes before single-register changes start
      write_register(mf3_pkg::REG_IMAGE_WIDTH, 16'd5);
      write_register(mf3_pkg::REG_IMAGE_HEIGHT, 16'd4);

      // random phases: whole frames mostly, sometimes a frame cut short
      while (random_pixels < RANDOM_PIXELS) begin
         if (random_pixels >= CALM_FROM) idle_enable = 1'b0;
         case ($urandom_range(0, 7))
            0:       w_raw = $urandom_range(0, 2);
            1:       w_raw = $urandom_range(9, 16);
            default: w_raw = $urandom_range(3, 8);
         endcase
         h_raw  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
         // upper bits beyond the register width are don't-care
         w_data = (16'($urandom) & 16'hF800) | 16'(w_raw);
         h_data = (16'($urandom) & 16'hF000) | 16'(h_raw);
         case ($urandom_range(0, 3))
            0: write_register(mf3_pkg::REG_IMAGE_WIDTH, w_data);
            1: write_register(mf3_pkg::REG_IMAGE_HEIGHT, h_data);
            2: begin
               write_register(mf3_pkg::REG_IMAGE_HEIGHT, h_data);
               write_register(mf3_pkg::REG_IMAGE_WIDTH, w_data);
            end
            default: begin
               write_register(mf3_pkg::REG_IMAGE_WIDTH, w_data);
               write_register(mf3_pkg::REG_IMAGE_HEIGHT, h_data);
            end
         endcase
         frame_len = effective_width() * effective_height();
         if ($urandom_range(0, 4) == 0)
            burst = $urandom_range(1, frame_len - 1);
         else
            burst = frame_len * $urandom_range(1, 2);
         queue_random_pixels(burst);
         random_pixels += burst;
         wait_for_drain();
      end

      // calm tail: no idling on either side, the frame goes on where it stopped
      idle_enable = 1'b0;
      queue_random_pixels(CALM_PIXELS);
      wait_for_drain();

      // late results would show up here
      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_median_filter_3x3_rgb OK");
      else
         $display("tb_median_filter_3x3_rgb NOT OK");
      $finish;
   end

endmodule
